>>> rtl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, constants and character helpers for the timestamp text to
// epoch seconds unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  // Number of token slots: year, day, hour, minute, second, millisecond
  localparam int unsigned MaxFields = 6;
  localparam int unsigned FieldIdxW = $clog2(MaxFields);

  // Keyword tracking: 0..7 chars matched, KwFail once no match is possible
  localparam logic [3:0] KwLen  = 4'd7;
  localparam logic [3:0] KwFail = 4'd8;

  // Calendar constants
  localparam logic [16:0] EpochYear   = 17'd1970;
  localparam logic [16:0] CenturyBase = 17'd1900;
  localparam logic [15:0] MaxDay      = 16'd366;
  localparam logic [15:0] MaxHour     = 16'd23;
  localparam logic [15:0] MaxMinSec   = 16'd59;
  localparam logic [15:0] MaxMillis   = 16'd999;
  // Leap days in years 1..1969
  localparam logic [15:0] LeapsBefore = 16'd477;
  // ceil(2^24 / 100): exact floor(x / 100) for every x below 2^17
  localparam logic [17:0] Recip100    = 18'd167773;
  localparam int unsigned Recip100Sh  = 24;
  localparam logic [37:0] PresentSecs = 38'd2147483647;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusCount   = 2'd1,
    StatusRange   = 2'd2,
    StatusPresent = 2'd3
  } status_e;

  // Parsed fields handed from the character parser to the epoch arithmetic
  typedef struct packed {
    logic                        kw_hit;
    logic                        bad_count;
    logic [2:0]                  count;
    logic [1:0]                  first_len;
    logic [MaxFields-1:0][15:0]  values;
  } fields_t;

  // Token separators: - / . : ( ) , ;
  function automatic logic is_delim(input logic [7:0] c);
    return (c == 8'h2d) || (c == 8'h2f) || (c == 8'h2e) || (c == 8'h3a) ||
           (c == 8'h28) || (c == 8'h29) || (c == 8'h2c) || (c == 8'h3b);
  endfunction

  // Lower-case letters of the keyword "present"
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h70;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h65;
      3'd3:    ch = 8'h73;
      3'd4:    ch = 8'h65;
      3'd5:    ch = 8'h6e;
      3'd6:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tte_parser.sv
// ----------------------------------------------------------------------------
// tte_parser
// Per-character tokenizer: splits on delimiters, accumulates leading digits
// of each token with saturation, tracks the keyword match, and hands the
// field set to the arithmetic on the final character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tte_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      char_code_i,
  input  wire logic            last_char_i,
  output logic                 fld_valid_o,
  input  wire logic            fld_ready_i,
  output tte_pkg::fields_t     fld_o
);
  import tte_pkg::*;

  logic [2:0]  fc_q, fc_d;
  logic        in_tok_q, in_tok_d;
  logic        dstop_q, dstop_d;
  logic [1:0]  ftl_q, ftl_d;
  logic        tmf_q, tmf_d;
  logic [3:0]  kw_q, kw_d;
  logic [MaxFields-1:0][15:0] fv_q, fv_d;

  logic        fld_valid_q;
  fields_t     fld_q;

  logic        accept;
  logic [7:0]  lower;
  logic        new_tok;
  logic        is_digit;
  logic [FieldIdxW-1:0] idx;
  logic [15:0] cur;
  logic [19:0] acc;

  // Hand-off slot is free when empty or being drained this cycle
  assign in_ready_o = !fld_valid_q || fld_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next tokenizer state for the current character
  always_comb begin
    fc_d     = fc_q;
    in_tok_d = in_tok_q;
    dstop_d  = dstop_q;
    ftl_d    = ftl_q;
    tmf_d    = tmf_q;
    fv_d     = fv_q;
    new_tok  = 1'b0;
    idx      = '0;
    cur      = '0;
    acc      = '0;

    lower    = ((char_code_i >= 8'h41) && (char_code_i <= 8'h5a)) ?
               char_code_i + 8'd32 : char_code_i;
    is_digit = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);

    // Case-insensitive keyword tracking
    if ((kw_q < KwLen) && (lower == kw_char(kw_q[2:0]))) begin
      kw_d = kw_q + 4'd1;
    end else begin
      kw_d = KwFail;
    end

    if (is_delim(char_code_i)) begin
      in_tok_d = 1'b0;
    end else begin
      new_tok = !in_tok_q;
      if (new_tok) begin
        in_tok_d = 1'b1;
        dstop_d  = 1'b0;
        if (fc_q < 3'(MaxFields)) begin
          fc_d = fc_q + 3'd1;
        end else begin
          tmf_d = 1'b1;
        end
      end
      if (!tmf_d) begin
        if ((fc_d == 3'd1) && (ftl_q != 2'd3)) begin
          ftl_d = ftl_q + 2'd1;
        end
        idx = FieldIdxW'(fc_d - 3'd1);
        cur = new_tok ? 16'd0 : fv_q[idx];
        // value * 10 + digit, saturating at 16 bits
        acc = 20'({cur, 3'b000}) + 20'({cur, 1'b0}) + 20'(char_code_i[3:0]);
        if (!dstop_d && is_digit) begin
          fv_d[idx] = (|acc[19:16]) ? 16'hffff : acc[15:0];
        end else begin
          dstop_d   = 1'b1;
          fv_d[idx] = cur;
        end
      end
    end
  end

  // Control state; cleared after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q     <= '0;
      in_tok_q <= 1'b0;
      dstop_q  <= 1'b0;
      ftl_q    <= '0;
      tmf_q    <= 1'b0;
      kw_q     <= '0;
    end else if (accept) begin
      if (last_char_i) begin
        fc_q     <= '0;
        in_tok_q <= 1'b0;
        dstop_q  <= 1'b0;
        ftl_q    <= '0;
        tmf_q    <= 1'b0;
        kw_q     <= '0;
      end else begin
        fc_q     <= fc_d;
        in_tok_q <= in_tok_d;
        dstop_q  <= dstop_d;
        ftl_q    <= ftl_d;
        tmf_q    <= tmf_d;
        kw_q     <= kw_d;
      end
    end
  end

  // Token values: only read after a token has written its slot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fv_q <= fv_d;
    end
  end

  // Hand-off request valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      fld_valid_q <= accept && last_char_i;
    end
  end

  // Hand-off payload
  always_ff @(posedge clk_i) begin
    if (accept && last_char_i) begin
      fld_q.kw_hit    <= (kw_d == KwLen);
      fld_q.bad_count <= tmf_d || (fc_d == 3'd0);
      fld_q.count     <= fc_d;
      fld_q.first_len <= ftl_d;
      fld_q.values    <= fv_d;
    end
  end

  assign fld_valid_o = fld_valid_q;
  assign fld_o       = fld_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= 3'(MaxFields))
    else $error("field count above slot count");

  a_first_len_needs_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ftl_q != 2'd0) |-> (fc_q != 3'd0))
    else $error("first token length without a token");

  a_kw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kw_q <= KwFail)
    else $error("keyword progress out of range");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_char_i) |=>
      (fc_q == 3'd0) && (kw_q == 4'd0) && !in_tok_q && !tmf_q && fld_valid_q)
    else $error("state not cleared after final character");

endmodule

`default_nettype wire

>>> rtl/tte_epoch_calc.sv
// ----------------------------------------------------------------------------
// tte_epoch_calc
// Three-stage arithmetic: defaults and range checks, leap-day count and day
// total, then seconds and overflow check into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tte_epoch_calc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fld_valid_i,
  output logic                   fld_ready_o,
  input  wire tte_pkg::fields_t  fld_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tte_pkg::status_e       status_o,
  output logic [37:0]            epoch_seconds_o,
  output logic [9:0]             millis_o
);
  import tte_pkg::*;

  // Stage handshake
  logic out_free, s3_free, s2_free;
  logic s2_valid_q, s3_valid_q, out_valid_q;

  // Stage 2 signals
  logic [16:0] yr, x, yd;
  logic [15:0] da, hr, mn, sc, mv;
  logic        range_bad;
  status_e     st2;
  logic [34:0] prod;
  logic [16:0] tod;

  status_e     s2_status_q;
  logic [34:0] s2_prod_q;
  logic [16:0] s2_x_q, s2_yd_q, s2_tod_q;
  logic [8:0]  s2_da_q;
  logic [9:0]  s2_mv_q;

  // Stage 3 signals
  logic [9:0]  q100;
  logic [15:0] leaps;
  logic [24:0] days;

  status_e     s3_status_q;
  logic [24:0] s3_days_q;
  logic [16:0] s3_tod_q;
  logic [9:0]  s3_mv_q;

  // Output stage signals
  logic [41:0] tsec;
  status_e     st_out;
  logic [37:0] secs_out;
  logic [9:0]  ms_out;

  status_e     status_q;
  logic [37:0] secs_q;
  logic [9:0]  ms_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s3_free     = !s3_valid_q || out_free;
  assign s2_free     = !s2_valid_q || s3_free;
  assign fld_ready_o = s2_free;

  // Defaults for missing fields, range checks, reciprocal multiply for /100
  always_comb begin
    yr = {1'b0, fld_i.values[0]} + ((fld_i.first_len == 2'd2) ? CenturyBase : 17'd0);
    da = (fld_i.count >= 3'd2) ? fld_i.values[1] : 16'd1;
    hr = (fld_i.count >= 3'd3) ? fld_i.values[2] : 16'd0;
    mn = (fld_i.count >= 3'd4) ? fld_i.values[3] : 16'd0;
    sc = (fld_i.count >= 3'd5) ? fld_i.values[4] : 16'd0;
    mv = (fld_i.count >= 3'd6) ? fld_i.values[5] : 16'd0;

    range_bad = (yr < EpochYear) || (da == 16'd0) || (da > MaxDay) ||
                (hr > MaxHour) || (mn > MaxMinSec) || (sc > MaxMinSec) ||
                (mv > MaxMillis);

    if (fld_i.kw_hit) begin
      st2 = StatusPresent;
    end else if (fld_i.bad_count) begin
      st2 = StatusCount;
    end else if (range_bad) begin
      st2 = StatusRange;
    end else begin
      st2 = StatusOk;
    end

    x    = yr - 17'd1;
    yd   = yr - EpochYear;
    prod = 35'(x) * 35'(Recip100);
    tod  = 17'(hr[4:0]) * 17'd3600 + 17'(mn[5:0]) * 17'd60 + 17'(sc[5:0]);
  end

  // Leap days since 1970 and total day count
  always_comb begin
    q100  = s2_prod_q[Recip100Sh+9:Recip100Sh];
    leaps = {1'b0, s2_x_q[16:2]} - 16'(q100) + 16'(q100[9:2]) - LeapsBefore;
    days  = 25'(s2_yd_q) * 25'd365 + 25'(leaps) + 25'(s2_da_q) - 25'd1;
  end

  // Seconds, overflow check and error masking
  always_comb begin
    tsec     = 42'(s3_days_q) * 42'd86400 + 42'(s3_tod_q);
    st_out   = s3_status_q;
    secs_out = '0;
    ms_out   = '0;
    case (s3_status_q)
      StatusOk: begin
        if (|tsec[41:38]) begin
          st_out = StatusRange;
        end else begin
          secs_out = tsec[37:0];
          ms_out   = s3_mv_q;
        end
      end
      StatusPresent: begin
        secs_out = PresentSecs;
      end
      default: begin
        secs_out = '0;
      end
    endcase
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= fld_valid_i;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (s2_free && fld_valid_i) begin
      s2_status_q <= st2;
      s2_prod_q   <= prod;
      s2_x_q      <= x;
      s2_yd_q     <= yd;
      s2_tod_q    <= tod;
      s2_da_q     <= da[8:0];
      s2_mv_q     <= mv[9:0];
    end
    if (s3_free && s2_valid_q) begin
      s3_status_q <= s2_status_q;
      s3_days_q   <= days;
      s3_tod_q    <= s2_tod_q;
      s3_mv_q     <= s2_mv_q;
    end
    if (out_free && s3_valid_q) begin
      status_q <= st_out;
      secs_q   <= secs_out;
      ms_q     <= ms_out;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign epoch_seconds_o = secs_q;
  assign millis_o        = ms_q;

  // Checks
  a_err_no_millis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != StatusOk)) |-> (ms_q == 10'd0))
    else $error("millis nonzero on non-ok result");

  a_present_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == StatusPresent)) |-> (secs_q == PresentSecs))
    else $error("keyword result has wrong seconds");

  a_millis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (ms_q <= 10'd999))
    else $error("millis out of range");

  a_s3_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && out_free) |=> out_valid_q)
    else $error("stage 3 request lost");

endmodule

`default_nettype wire

>>> rtl/timestamp_text_to_epoch_unit.sv
// ----------------------------------------------------------------------------
// timestamp_text_to_epoch_unit
// Parses "yyyy:ddd-hh:mm:ss:msc" one character per request and returns a
// status, seconds since 1970 and milliseconds on the final character.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   in       | input     | in_valid_i/in_ready_o  | char_code_i, last_char_i
//   out      | output    | out_valid_o/out_ready_i| status_o, epoch_seconds_o,
//            |           |                        | millis_o
//
// One character is taken every cycle while the stages are not backed up; one
// result follows each final character. A result passes through the hand-off
// register, check stage, day-count stage and result register after its final
// character is accepted; the last stage holds the 25x17 seconds multiply.
// Reset clears the tokenizer and all stage valid bits; no clearing pass.
// A stalled output backs up through the stages; once a finished request waits
// in the hand-off register, every character is held off until it moves on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timestamp_text_to_epoch_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        last_char_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [37:0]      epoch_seconds_o,
  output logic [9:0]       millis_o
);
  import tte_pkg::*;

  logic    fld_valid;
  logic    fld_ready;
  fields_t fld;
  status_e status;

  // Character tokenizer
  tte_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .fld_valid_o (fld_valid),
    .fld_ready_i (fld_ready),
    .fld_o       (fld)
  );

  // Epoch arithmetic pipeline
  tte_epoch_calc u_calc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fld_valid_i     (fld_valid),
    .fld_ready_o     (fld_ready),
    .fld_i           (fld),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status),
    .epoch_seconds_o (epoch_seconds_o),
    .millis_o        (millis_o)
  );

  assign status_o = 2'(status);

endmodule

`default_nettype wire

>>> verif/timestamp_text_to_epoch_unit_tb.sv
// ----------------------------------------------------------------------------
// timestamp_text_to_epoch_unit_tb
// Streams timestamp texts into the unit one character per request and checks
// every result against a cycle-free model of the parser and epoch arithmetic.
// A short directed set covers field limits, the keyword, delimiter runs and
// token corner cases, then random texts follow, mostly well formed. The
// sender idles in random bursts and the receiver stalls on its own pattern,
// with one long hold-off that backs the unit up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_text_to_epoch_unit_tb;

  import tte_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomChars = 1800;
  localparam longint unsigned SecsMax = 64'd274877906943;
  localparam logic [55:0] KwWord = "present";
  localparam logic [63:0] DelimSet = "-/.:(),;";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  typedef struct packed {
    status_e     status;
    logic [37:0] secs;
    logic [9:0]  ms;
  } epoch_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_code_i;
  logic        last_char_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [37:0] epoch_seconds_o;
  logic [9:0]  millis_o;

  char_req_t  pending_chars[$];
  epoch_res_t due_results[$];
  logic [7:0] text_buf[$];
  int unsigned error_cnt;
  int unsigned cycle_cnt;

  // Parser state of the model
  logic [2:0]  tok_count;
  logic        in_tok;
  logic        dig_stop;
  logic [1:0]  first_len;
  logic        over_count;
  logic [15:0] vals[MaxFields];
  logic [3:0]  kw_pos;

  timestamp_text_to_epoch_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .epoch_seconds_o(epoch_seconds_o),
    .millis_o       (millis_o)
  );

  // Clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic is_sep(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (c == DelimSet[63-8*i -: 8]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Gregorian leap days in years 1..y
  function automatic longint unsigned leap_days(input longint unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic void clear_parser();
    tok_count  = '0;
    in_tok     = 1'b0;
    dig_stop   = 1'b0;
    first_len  = '0;
    over_count = 1'b0;
    kw_pos     = '0;
    for (int i = 0; i < MaxFields; i++) vals[i] = '0;
  endfunction

  // Advance the tokenizer by one character
  function automatic void scan_char(input logic [7:0] c);
    logic [7:0]  low;
    int unsigned acc;
    low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (kw_pos < KwLen && low == KwWord[55-8*kw_pos -: 8]) kw_pos = kw_pos + 4'd1;
    else kw_pos = KwFail;

    if (is_sep(c)) begin
      in_tok = 1'b0;
      return;
    end
    if (!in_tok) begin
      in_tok   = 1'b1;
      dig_stop = 1'b0;
      if (tok_count < MaxFields) begin
        vals[tok_count] = '0;
        tok_count = tok_count + 3'd1;
      end else begin
        over_count = 1'b1;
      end
    end
    if (over_count) return;
    if (tok_count == 3'd1 && first_len < 2'd3) first_len = first_len + 2'd1;
    if (!dig_stop && c >= "0" && c <= "9") begin
      acc = vals[tok_count-1] * 10 + (c - "0");
      vals[tok_count-1] = (acc > 65535) ? 16'hffff : acc[15:0];
    end else begin
      dig_stop = 1'b1;
    end
  endfunction

  // Status, seconds and milliseconds for the fields gathered so far
  function automatic epoch_res_t fields_to_epoch();
    epoch_res_t      r;
    longint unsigned yr, da, hr, mn, sc, mv, days, t;
    r.status = StatusOk;
    r.secs   = '0;
    r.ms     = '0;
    if (kw_pos == KwLen) begin
      r.status = StatusPresent;
      r.secs   = 38'd2147483647;
    end else if (over_count || tok_count == 3'd0) begin
      r.status = StatusCount;
    end else begin
      yr = vals[0] + ((first_len == 2'd2) ? 1900 : 0);
      da = (tok_count >= 2) ? vals[1] : 1;
      hr = (tok_count >= 3) ? vals[2] : 0;
      mn = (tok_count >= 4) ? vals[3] : 0;
      sc = (tok_count >= 5) ? vals[4] : 0;
      mv = (tok_count >= 6) ? vals[5] : 0;
      if (yr < 1970 || da < 1 || da > 366 || hr > 23 || mn > 59 || sc > 59 || mv > 999) begin
        r.status = StatusRange;
      end else begin
        days = 365 * (yr - 1970) + leap_days(yr - 1) - leap_days(1969) + (da - 1);
        t = days * 86400 + hr * 3600 + mn * 60 + sc;
        if (t > SecsMax) begin
          r.status = StatusRange;
        end else begin
          r.secs = t[37:0];
          r.ms   = mv[9:0];
        end
      end
    end
    return r;
  endfunction

  // Model update for one accepted request
  function automatic void track_char(input logic [7:0] c, input logic last);
    scan_char(c);
    if (last) begin
      due_results.push_back(fields_to_epoch());
      clear_parser();
    end
  endfunction

  // Text building helpers
  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void put_num(input int unsigned v, input int unsigned w);
    string s;
    s = $sformatf("%0d", v);
    while (s.len() < w) s = {"0", s};
    put_str(s);
  endfunction

  function automatic void put_sep();
    int unsigned n;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1;
    for (int i = 0; i < n; i++) text_buf.push_back(DelimSet[63-8*$urandom_range(0, 7) -: 8]);
  endfunction

  function automatic void end_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      pending_chars.push_back('{ch: text_buf[i], last: (i == text_buf.size() - 1)});
    end
    text_buf.delete();
  endfunction

  function automatic void directed_text(input string s);
    put_str(s);
    end_text();
  endfunction

  // One random text: mostly well-formed timestamps, some keyword and noise
  function automatic void random_text();
    int unsigned kind, nf, v, w;
    int unsigned lim[6];
    int unsigned wid[6];
    logic [7:0]  c;
    lim = '{65535, 366, 23, 59, 59, 999};
    wid = '{4, 3, 2, 2, 2, 3};
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      for (int i = 0; i < 7; i++) begin
        c = KwWord[55-8*i -: 8];
        if ($urandom_range(0, 1)) c = c - 8'd32;
        if (!(kind == 0 && i == 3)) text_buf.push_back(c);
      end
      if (kind == 1) put_sep();
      if (kind == 2) text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 12) begin
      nf = $urandom_range(1, 8);
      for (int i = 0; i < nf; i++) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      nf = ($urandom_range(0, 19) == 0) ? 7 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) put_sep();
      for (int f = 0; f < nf; f++) begin
        if (f > 0) put_sep();
        if (f == 0) begin
          case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 99);
            1:       v = $urandom_range(1900, 1969);
            2:       v = $urandom_range(10600, 10700);
            3:       v = $urandom_range(0, 99999);
            default: v = $urandom_range(1970, 2100);
          endcase
          w = (v < 100 && $urandom_range(0, 1)) ? 2 : 4;
        end else begin
          w = wid[(f > 5) ? 5 : f];
          if ($urandom_range(0, 9) == 0) begin
            v = (f == 1 && $urandom_range(0, 1)) ? 0 : lim[(f > 5) ? 5 : f] + $urandom_range(1, 50);
          end else begin
            v = (f == 1) ? $urandom_range(1, 366) : $urandom_range(0, lim[(f > 5) ? 5 : f]);
          end
        end
        if ($urandom_range(0, 7) == 0) w = 0;
        put_num(v, w);
        if ($urandom_range(0, 14) == 0) begin
          text_buf.push_back($urandom_range(0, 1) ? "x" : 8'h80 | 8'($urandom_range(0, 127)));
          if ($urandom_range(0, 1)) put_num($urandom_range(0, 99), 0);
        end
      end
      if ($urandom_range(0, 9) == 0) put_sep();
    end
    end_text();
  endfunction

  // Driver: bursts of requests with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i) begin : drive
    char_req_t req;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) track_char(char_code_i, last_char_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          req = pending_chars.pop_front();
          in_valid_i  <= 1'b1;
          char_code_i <= req.ch;
          last_char_i <= req.last;
          if (burst_left > 1) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: changing stall patterns plus one long hold-off
  int unsigned seen_results;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned stall_mode;
  int unsigned mode_left;
  logic [1:0]  stall_phase;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) seen_results = seen_results + 1;
      if (!hold_done && seen_results >= 20) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left = mode_left - 1;
      end
      stall_phase = stall_phase + 2'd1;
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (stall_phase == 2'd0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin : watch
    epoch_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d secs=%0d ms=%0d",
                 $time, status_o, epoch_seconds_o, millis_o);
        error_cnt = error_cnt + 1;
      end else begin
        want = due_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          error_cnt = error_cnt + 1;
        end
        if (epoch_seconds_o !== want.secs) begin
          $display("%0t: epoch_seconds expected %0d actual %0d",
                   $time, want.secs, epoch_seconds_o);
          error_cnt = error_cnt + 1;
        end
        if (millis_o !== want.ms) begin
          $display("%0t: millis expected %0d actual %0d", $time, want.ms, millis_o);
          error_cnt = error_cnt + 1;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    last_char_i = 1'b0;
    out_ready_i = 1'b0;
    error_cnt   = 0;
    cycle_cnt   = 0;
    burst_left  = 8;
    gap_left    = 0;
    seen_results = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    stall_mode  = 0;
    mode_left   = 50;
    stall_phase = '0;
    clear_parser();

    // Directed texts
    directed_text("2024:001-00:00:00:000");
    directed_text("1970:001-00:00:00:000");
    directed_text("2000:366-23:59:59:999");
    directed_text("70:001");
    directed_text("2000");
    directed_text("present");
    directed_text("PRESENT");
    directed_text("PrEsEnT");
    directed_text("presents");
    directed_text("prese");
    directed_text("present:");
    directed_text("::--,;()");
    directed_text("1:2:3:4:5:6:7");
    directed_text("1969:365-23:59:59");
    directed_text("2000:000");
    directed_text("2000:367");
    directed_text("2000:001-24");
    directed_text("2000:001-00:60:00");
    directed_text("2000:001-00:00:60:1000");
    directed_text("99999:001");
    directed_text("10680:366-23:59:59");
    directed_text("2000a5:1x2/3..4,,5;(6)");
    directed_text("abc:7");
    text_buf.push_back(8'hff);
    text_buf.push_back(8'h00);
    end_text();
    text_buf.push_back(8'h00);
    end_text();

    // Random texts
    while (pending_chars.size() < RandomChars) random_text();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_chars.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
